// ===== sv/delta_list_sleep_queue_defines.svh =====
// ----------------------------------------------------------------------------
// delta_list_sleep_queue_defines
// Assertion macros for the sleep queue.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_SLEEP_QUEUE_DEFINES_SVH
`define DELTA_LIST_SLEEP_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define DLSQ_ASSERT_NOW(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define DLSQ_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define DLSQ_ASSERT_NOW(lbl, clk, rst, a, b)
`define DLSQ_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// ===== sv/dlsq_pkg.sv =====
// ----------------------------------------------------------------------------
// dlsq_pkg
// Types and constants of the delta-list sleep queue.
// ----------------------------------------------------------------------------
package dlsq_pkg;

  localparam int unsigned CAPACITY_DEF  = 32;
  localparam int unsigned TIME_BITS_DEF = 16;
  localparam int unsigned ID_BITS_DEF   = 8;

  typedef enum logic [2:0] {
    KIND_ACCEPT  = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_ZERO    = 3'd2,
    KIND_WOKEN   = 3'd3,
    KIND_NO_WAKE = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WK_RD,
    ST_WK_CHK,
    ST_SH_RD,
    ST_SH_WR,
    ST_FIX,
    ST_PUT,
    ST_DONE,
    ST_TK_RD,
    ST_TK_CHK,
    ST_TK_END
  } state_t;

endpackage

// ===== sv/dlsq_mem.sv =====
// ----------------------------------------------------------------------------
// dlsq_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dlsq_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 24,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dlsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlsq_ctrl
// Sequencer: walks, shifts and pops the circular delta list in memory.
// ----------------------------------------------------------------------------
module dlsq_ctrl #(
  parameter int unsigned CAPACITY  = dlsq_pkg::CAPACITY_DEF,
  parameter int unsigned TIME_BITS = dlsq_pkg::TIME_BITS_DEF,
  parameter int unsigned ID_BITS   = dlsq_pkg::ID_BITS_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned EW = ID_BITS + TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [ID_BITS-1:0]   thread_id,
  input  logic [TIME_BITS-1:0] sleep_ticks,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dlsq_pkg::kind_t      kind,
  output logic [ID_BITS-1:0]   woken_id,
  output logic                 last,
  output logic                 queue_empty,
  output logic [CW-1:0]        occupancy,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [EW-1:0]        mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  input  logic [EW-1:0]        mem_rdata
);
  import dlsq_pkg::*;

  state_t               state, state_next;
  logic [AW-1:0]        head, head_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        idx, idx_next;
  logic [CW-1:0]        pos, pos_next;
  logic [TIME_BITS-1:0] cum, cum_next;
  logic [ID_BITS-1:0]   tid, tid_next;
  logic [TIME_BITS-1:0] tval, tval_next;
  logic [EW-1:0]        sav, sav_next;
  logic                 first, first_next;
  logic                 pend, pend_next;
  logic [ID_BITS-1:0]   pend_id, pend_id_next;
  logic [CW-1:0]        pend_occ, pend_occ_next;
  kind_t                res_kind, res_kind_next;

  logic                 ld, ld_last;
  kind_t                ld_kind;
  logic [ID_BITS-1:0]   ld_id;
  logic [CW-1:0]        ld_occ;
  logic                 free;
  logic [CW-1:0]        ra_l, wa_l;
  logic [ID_BITS-1:0]   rd_id;
  logic [TIME_BITS-1:0] rd_dlt, dec, nd;
  logic [TIME_BITS:0]   sum;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = {1'b0, CW'(h)} + {1'b0, l};
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  assign rd_id     = mem_rdata[EW-1:TIME_BITS];
  assign rd_dlt    = mem_rdata[TIME_BITS-1:0];
  assign dec       = first ? rd_dlt - TIME_BITS'(1) : rd_dlt;
  assign nd        = tval - cum;
  assign sum       = {1'b0, cum} + {1'b0, rd_dlt};
  assign free      = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign mem_raddr = phys(head, ra_l);
  assign mem_waddr = phys(head, wa_l);

  always_comb begin
    state_next    = state;
    head_next     = head;
    count_next    = count;
    idx_next      = idx;
    pos_next      = pos;
    cum_next      = cum;
    tid_next      = tid;
    tval_next     = tval;
    sav_next      = sav;
    first_next    = first;
    pend_next     = pend;
    pend_id_next  = pend_id;
    pend_occ_next = pend_occ;
    res_kind_next = res_kind;
    ld            = 1'b0;
    ld_kind       = KIND_ACCEPT;
    ld_id         = '0;
    ld_last       = 1'b1;
    ld_occ        = count;
    ra_l          = idx;
    wa_l          = idx;
    mem_we        = 1'b0;
    mem_wdata     = mem_rdata;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          tid_next  = thread_id;
          tval_next = sleep_ticks;
          idx_next  = '0;
          cum_next  = '0;
          if (func == 1'b0) begin
            if (count == CW'(CAPACITY)) begin
              res_kind_next = KIND_FULL;
              state_next    = ST_DONE;
            end else if (sleep_ticks == '0) begin
              res_kind_next = KIND_ZERO;
              state_next    = ST_DONE;
            end else begin
              state_next = ST_WK_RD;
            end
          end else begin
            if (count == '0) begin
              res_kind_next = KIND_NO_WAKE;
              state_next    = ST_DONE;
            end else begin
              first_next = 1'b1;
              state_next = ST_TK_RD;
            end
          end
        end
      end
      ST_WK_RD: begin
        if (idx == count) begin
          pos_next   = idx;
          state_next = ST_PUT;
        end else begin
          state_next = ST_WK_CHK;
        end
      end
      ST_WK_CHK: begin
        if (sum <= {1'b0, tval}) begin
          cum_next   = sum[TIME_BITS-1:0];
          idx_next   = idx + CW'(1);
          state_next = ST_WK_RD;
        end else begin
          pos_next = idx;
          sav_next = mem_rdata;
          if (count > idx + CW'(1)) begin
            idx_next   = count - CW'(1);
            state_next = ST_SH_RD;
          end else begin
            state_next = ST_FIX;
          end
        end
      end
      ST_SH_RD: begin
        state_next = ST_SH_WR;
      end
      ST_SH_WR: begin
        mem_we = 1'b1;
        wa_l   = idx + CW'(1);
        if (idx == pos + CW'(1)) begin
          state_next = ST_FIX;
        end else begin
          idx_next   = idx - CW'(1);
          state_next = ST_SH_RD;
        end
      end
      ST_FIX: begin
        mem_we     = 1'b1;
        wa_l       = pos + CW'(1);
        mem_wdata  = {sav[EW-1:TIME_BITS], sav[TIME_BITS-1:0] - nd};
        state_next = ST_PUT;
      end
      ST_PUT: begin
        mem_we        = 1'b1;
        wa_l          = pos;
        mem_wdata     = {tid, nd};
        count_next    = count + CW'(1);
        res_kind_next = KIND_ACCEPT;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (free) begin
          ld         = 1'b1;
          ld_kind    = res_kind;
          state_next = ST_IDLE;
        end
      end
      ST_TK_RD: begin
        ra_l       = '0;
        state_next = ST_TK_CHK;
      end
      ST_TK_CHK: begin
        wa_l      = '0;
        mem_wdata = {rd_id, dec};
        if (dec == '0) begin
          if (!pend || free) begin
            ld            = pend;
            ld_kind       = KIND_WOKEN;
            ld_id         = pend_id;
            ld_last       = 1'b0;
            ld_occ        = pend_occ;
            pend_next     = 1'b1;
            pend_id_next  = rd_id;
            pend_occ_next = count - CW'(1);
            count_next    = count - CW'(1);
            head_next     = (head == AW'(CAPACITY - 1)) ? '0 : head + AW'(1);
            first_next    = 1'b0;
            state_next    = (count == CW'(1)) ? ST_TK_END : ST_TK_RD;
          end
        end else if (pend) begin
          if (free) begin
            ld         = 1'b1;
            ld_kind    = KIND_WOKEN;
            ld_id      = pend_id;
            ld_occ     = pend_occ;
            pend_next  = 1'b0;
            state_next = ST_IDLE;
          end
        end else begin
          mem_we        = first;
          res_kind_next = KIND_NO_WAKE;
          state_next    = ST_DONE;
        end
      end
      ST_TK_END: begin
        if (free) begin
          ld         = 1'b1;
          ld_kind    = KIND_WOKEN;
          ld_id      = pend_id;
          ld_occ     = pend_occ;
          pend_next  = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      pend      <= pend_next;
      out_valid <= ld || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    pos      <= pos_next;
    cum      <= cum_next;
    tid      <= tid_next;
    tval     <= tval_next;
    sav      <= sav_next;
    first    <= first_next;
    pend_id  <= pend_id_next;
    pend_occ <= pend_occ_next;
    res_kind <= res_kind_next;
    if (ld) begin
      kind        <= ld_kind;
      woken_id    <= ld_id;
      last        <= ld_last;
      queue_empty <= (ld_occ == '0);
      occupancy   <= ld_occ;
    end
  end

endmodule

// ===== sv/delta_list_sleep_queue.sv =====
// Add: walks entries to the insert point, shifts later entries up, fixes the next delta, writes the entry.
// Tick: examines entries from the head, decrementing the first; one result beat per woken thread.
// One item at a time; the entry memory, one read and one write port, sets the pace.
// Results sit in an output register, so the next item is taken while one waits.
// Reset empties the queue (count and head cleared); entry memory is not cleared.
// ----------------------------------------------------------------------------
// delta_list_sleep_queue
// Sleep queue kept as a delta list in a circular entry memory.
// ----------------------------------------------------------------------------
`include "delta_list_sleep_queue_defines.svh"
module delta_list_sleep_queue #(
  parameter int unsigned CAPACITY  = dlsq_pkg::CAPACITY_DEF,
  parameter int unsigned TIME_BITS = dlsq_pkg::TIME_BITS_DEF,
  parameter int unsigned ID_BITS   = dlsq_pkg::ID_BITS_DEF,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 func,
  input  logic [ID_BITS-1:0]   thread_id,
  input  logic [TIME_BITS-1:0] sleep_ticks,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           kind,
  output logic [ID_BITS-1:0]   woken_id,
  output logic                 last,
  output logic                 queue_empty,
  output logic [CW-1:0]        occupancy
);
  import dlsq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned EW = ID_BITS + TIME_BITS;

  kind_t         kind_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  assign kind = kind_q;

  dlsq_ctrl #(
    .CAPACITY (CAPACITY),
    .TIME_BITS(TIME_BITS),
    .ID_BITS  (ID_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .thread_id  (thread_id),
    .sleep_ticks(sleep_ticks),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind_q),
    .woken_id   (woken_id),
    .last       (last),
    .queue_empty(queue_empty),
    .occupancy  (occupancy),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  dlsq_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(EW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  `DLSQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `DLSQ_ASSERT_NOW(a_occ_bound, clk, rst, out_valid, occupancy <= CW'(CAPACITY))
  `DLSQ_ASSERT_NOW(a_empty_match, clk, rst, out_valid, queue_empty == (occupancy == '0))
  `DLSQ_ASSERT_NOW(a_single_last, clk, rst, out_valid && kind_q != KIND_WOKEN, last)

endmodule

// ===== verif/delta_list_sleep_queue_checker.sv =====
// ----------------------------------------------------------------------------
// delta_list_sleep_queue_checker
// Watches both channels of the sleep queue, keeps a delta list of its own
// from accepted beats and compares every result beat with the oldest
// expected one.
// ----------------------------------------------------------------------------
module delta_list_sleep_queue_checker #(
  parameter int unsigned CAPACITY  = dlsq_pkg::CAPACITY_DEF,
  parameter int unsigned TIME_BITS = dlsq_pkg::TIME_BITS_DEF,
  parameter int unsigned ID_BITS   = dlsq_pkg::ID_BITS_DEF,
  parameter int unsigned CW        = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 func,
  input  logic [ID_BITS-1:0]   thread_id,
  input  logic [TIME_BITS-1:0] sleep_ticks,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [2:0]           kind,
  input  logic [ID_BITS-1:0]   woken_id,
  input  logic                 last,
  input  logic                 queue_empty,
  input  logic [CW-1:0]        occupancy,
  output int                   fail_count,
  output int                   pending_count
);
  import dlsq_pkg::*;

  typedef struct packed {
    kind_t              kind;
    logic [ID_BITS-1:0] id;
    logic               last;
    logic               empty;
    logic [CW-1:0]      occ;
  } wake_result_t;

  logic [ID_BITS-1:0]   sleeper_id[$];
  logic [TIME_BITS-1:0] sleeper_delta[$];
  wake_result_t         expected_results[$];

  function automatic wake_result_t make_result(kind_t k, logic [ID_BITS-1:0] id,
                                               logic lst);
    wake_result_t r;
    r.kind  = k;
    r.id    = id;
    r.last  = lst;
    r.empty = (sleeper_id.size() == 0);
    r.occ   = CW'(sleeper_id.size());
    return r;
  endfunction

  task automatic predict_beat(logic f, logic [ID_BITS-1:0] tid,
                              logic [TIME_BITS-1:0] t);
    longint               cum;
    int                   pos;
    int                   woken;
    logic [TIME_BITS-1:0] nd;
    logic [ID_BITS-1:0]   id;
    cum   = 0;
    pos   = 0;
    woken = 0;
    if (f == 1'b0) begin
      if (sleeper_id.size() >= CAPACITY) begin
        expected_results.push_back(make_result(KIND_FULL, '0, 1'b1));
      end else if (t == 0) begin
        expected_results.push_back(make_result(KIND_ZERO, '0, 1'b1));
      end else begin
        while (pos < sleeper_id.size() && cum + sleeper_delta[pos] <= t) begin
          cum += sleeper_delta[pos];
          pos++;
        end
        nd = t - TIME_BITS'(cum);
        if (pos < sleeper_id.size()) sleeper_delta[pos] = sleeper_delta[pos] - nd;
        sleeper_id.insert(pos, tid);
        sleeper_delta.insert(pos, nd);
        expected_results.push_back(make_result(KIND_ACCEPT, '0, 1'b1));
      end
    end else if (sleeper_id.size() == 0) begin
      expected_results.push_back(make_result(KIND_NO_WAKE, '0, 1'b1));
    end else begin
      sleeper_delta[0] = sleeper_delta[0] - 1'b1;
      while (sleeper_id.size() > 0 && sleeper_delta[0] == 0) begin
        id = sleeper_id.pop_front();
        void'(sleeper_delta.pop_front());
        expected_results.push_back(make_result(KIND_WOKEN, id, 1'b0));
        woken++;
      end
      if (woken == 0) expected_results.push_back(make_result(KIND_NO_WAKE, '0, 1'b1));
      else expected_results[$].last = 1'b1;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("%0t: result mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    wake_result_t e;
    if (rst) begin
      sleeper_id.delete();
      sleeper_delta.delete();
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with none expected");
        end else begin
          e = expected_results.pop_front();
          if (kind !== e.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, e.kind));
          if (woken_id !== e.id)
            report_mismatch($sformatf("woken_id %0d, expected %0d", woken_id, e.id));
          if (last !== e.last)
            report_mismatch($sformatf("last %0b, expected %0b", last, e.last));
          if (queue_empty !== e.empty)
            report_mismatch($sformatf("queue_empty %0b, expected %0b",
                                      queue_empty, e.empty));
          if (occupancy !== e.occ)
            report_mismatch($sformatf("occupancy %0d, expected %0d", occupancy, e.occ));
        end
      end
      if (in_valid && !in_stall) predict_beat(func, thread_id, sleep_ticks);
    end
    pending_count = expected_results.size();
  end

endmodule

// ===== verif/delta_list_sleep_queue_tb.sv =====
// ----------------------------------------------------------------------------
// delta_list_sleep_queue_tb
// Drives directed and random add and tick beats into the sleep queue with
// random gaps and output stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module delta_list_sleep_queue_tb;
  import dlsq_pkg::*;

  localparam int unsigned CW        = $clog2(CAPACITY_DEF + 1);
  localparam int          IDLE_LIMIT = 20000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     func = 1'b0;
  logic [ID_BITS_DEF-1:0]   thread_id = '0;
  logic [TIME_BITS_DEF-1:0] sleep_ticks = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [2:0]               kind;
  logic [ID_BITS_DEF-1:0]   woken_id;
  logic                     last;
  logic                     queue_empty;
  logic [CW-1:0]            occupancy;
  int                       fail_count;
  int                       pending_count;
  bit                       steady;
  int                       idle_cycles;

  always #10 clk = ~clk;

  delta_list_sleep_queue uut (.*);
  delta_list_sleep_queue_checker chk (.*);

  always @(posedge clk) begin
    if (!rst && !steady) out_stall <= ($urandom_range(99) < 16);
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_beat(logic f, logic [ID_BITS_DEF-1:0] id,
                           logic [TIME_BITS_DEF-1:0] t);
    while (!steady && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    thread_id   <= id;
    sleep_ticks <= t;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    int n;
    steady = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty tick, zero time, extremes, equal wake times, fill and drain
    send_beat(1'b1, 8'h00, 16'h0000);
    send_beat(1'b0, 8'hff, 16'h0000);
    send_beat(1'b0, 8'h00, 16'hffff);
    send_beat(1'b0, 8'hff, 16'h0001);
    send_beat(1'b0, 8'h55, 16'h0003);
    send_beat(1'b0, 8'haa, 16'h0003);
    send_beat(1'b0, 8'h0f, 16'h0002);
    repeat (4) send_beat(1'b1, 8'hff, 16'hffff);
    for (int i = 0; i < CAPACITY_DEF; i++)
      send_beat(1'b0, ID_BITS_DEF'(i), 16'h0002 + i[0]);
    send_beat(1'b0, 8'hf0, 16'h8000);
    repeat (4) send_beat(1'b1, 8'h00, 16'h0000);
    // hold the sender until every result has drained
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4 * CAPACITY_DEF + 8) @(posedge clk);
    // random: mostly short sleeps so ticks wake threads
    for (int i = 0; i < 120; i++) begin
      steady = (i >= 40 && i < 80);
      n = $urandom_range(99);
      if (n < 45)
        send_beat(1'b0, ID_BITS_DEF'($urandom), TIME_BITS_DEF'($urandom_range(1, 12)));
      else if (n < 52)
        send_beat(1'b0, ID_BITS_DEF'($urandom), TIME_BITS_DEF'($urandom));
      else if (n < 55)
        send_beat(1'b0, ID_BITS_DEF'($urandom), 16'h0000);
      else
        send_beat(1'b1, ID_BITS_DEF'($urandom), TIME_BITS_DEF'($urandom));
    end
    // tick the queue so the short sleepers wake
    steady = 1'b0;
    for (int i = 0; i < 40; i++) send_beat(1'b1, 8'h00, 16'h0000);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4 * CAPACITY_DEF + 8) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
